// ----- src/grafs_pkg.sv -----
// shared types and constants for the grid region pricing block
package grafs_pkg;

   localparam int LABEL_W    = 8;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int PRICE_W    = 31;

   localparam int DEF_MAX_ROWS = 128;
   localparam int DEF_MAX_COLS = 128;

   localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FENCE_MODE  = 2'd2;

   // neighbor directions: orthogonal first, then diagonals
   localparam logic [2:0] DIR_N  = 3'd0;
   localparam logic [2:0] DIR_S  = 3'd1;
   localparam logic [2:0] DIR_E  = 3'd2;
   localparam logic [2:0] DIR_W  = 3'd3;
   localparam logic [2:0] DIR_NW = 3'd4;
   localparam logic [2:0] DIR_NE = 3'd5;
   localparam logic [2:0] DIR_SW = 3'd6;
   localparam logic [2:0] DIR_SE = 3'd7;

   typedef struct packed {
      logic clear;
      logic start;
   } grafs_mac_ctl_type;

endpackage

// ----- src/grafs_mac.sv -----
// shift-add multiplier and saturating accumulator for region prices
module grafs_mac import grafs_pkg::*; #(
   parameter int AREA_W  = 15,
   parameter int FENCE_W = 17
) (
   input  logic                   clock,
   input  logic                   reset,
   input  grafs_mac_ctl_type      ctl,
   input  logic [AREA_W-1:0]      area,
   input  logic [FENCE_W-1:0]     fence,
   output logic                   busy,
   output logic [PRICE_W-1:0]     sum
);

   localparam int PW = AREA_W + FENCE_W;
   localparam int SW = (PW > PRICE_W) ? PW + 1 : PRICE_W + 1;

   localparam logic [1:0] M_IDLE = 2'd0;
   localparam logic [1:0] M_MUL  = 2'd1;
   localparam logic [1:0] M_ADD  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [PW-1:0]      mcand_ff, mcand_in;
   logic [FENCE_W-1:0] mplier_ff, mplier_in;
   logic [PW-1:0]      prod_ff, prod_in;
   logic [PRICE_W-1:0] sum_ff, sum_in;
   logic [PRICE_W-1:0] room;

   always_comb begin
      state_in  = state_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      sum_in    = sum_ff;
      room      = PRICE_MAX - sum_ff;
      case (state_ff)
         M_IDLE: begin
            if (ctl.clear) begin
               sum_in = '0;
            end
            if (ctl.start) begin
               mcand_in  = PW'(area);
               mplier_in = fence;
               prod_in   = '0;
               state_in  = M_MUL;
            end
         end
         M_MUL: begin
            if (mplier_ff == '0) begin
               state_in = M_ADD;
            end else begin
               if (mplier_ff[0]) begin
                  prod_in = prod_ff + mcand_ff;
               end
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
         end
         M_ADD: begin
            // saturate at the largest 31-bit value
            if (SW'(prod_ff) > SW'(room)) begin
               sum_in = PRICE_MAX;
            end else begin
               sum_in = sum_ff + PRICE_W'(prod_ff);
            end
            state_in = M_IDLE;
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
   end

   assign busy = (state_ff != M_IDLE);
   assign sum  = sum_ff;

endmodule

// ----- src/grid_region_area_fence_sum.sv -----
// top level: grid loader, flood-fill sequencer and region price accumulation
//
// usage
//  - csr port: write grid_width, grid_height and fence_mode while idle; a write
//    takes effect at the clock edge where csr_write_enable is high
//  - req channel: one transaction per grid cell in row-major order; cells load
//    one per cycle while the block is idle
//  - rsp channel: one transaction carrying total_price after the last cell
//  - sequence: after the last cell the block clears its visited map, scans
//    every cell, and runs the flood fill for each cell of a region (stack
//    pop, center label read, eight neighbor reads of the label and visited
//    memories, which have one read port each), plus a shift-add multiply
//    and accumulate per region
//  - a new grid's cells are taken only after the computation has finished;
//    the flood fill is limited by the one-read-per-cycle label and visited
//    memories
//  - req_stall is high for the whole computation
//  - reset clears control state and restores the register defaults; no
//    memory clearing pass is needed at reset since the visited map is swept
//    before every computation
//  - a stalled result holds in the output register; new cells still load,
//    and a following result waits until the held one is taken
module grid_region_area_fence_sum import grafs_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [LABEL_W-1:0]    req_cell_label,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PRICE_W-1:0]    rsp_total_price
);

   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CW    = $clog2(CELLS + 1);
   localparam int RB    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CB    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int WCB   = $clog2(MAX_COLS + 1);
   localparam int HCB   = $clog2(MAX_ROWS + 1);
   localparam int GW    = WCB + HCB;
   localparam int CMPW  = (GW > CW) ? GW : CW;
   localparam int FB    = CW + 2;
   localparam int SEW   = AW + RB + CB;
   localparam int DW    = 11;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_CLEAR    = 4'd1;
   localparam logic [3:0] ST_SCAN_RD  = 4'd2;
   localparam logic [3:0] ST_SCAN_CHK = 4'd3;
   localparam logic [3:0] ST_POP      = 4'd4;
   localparam logic [3:0] ST_POP_W    = 4'd5;
   localparam logic [3:0] ST_CTR      = 4'd6;
   localparam logic [3:0] ST_NRD      = 4'd7;
   localparam logic [3:0] ST_NEV      = 4'd8;
   localparam logic [3:0] ST_CEND     = 4'd9;
   localparam logic [3:0] ST_MAC      = 4'd10;
   localparam logic [3:0] ST_DONE     = 4'd11;

   // memories
   logic [LABEL_W-1:0] label_mem [CELLS];
   logic               visit_mem [CELLS];
   logic [SEW-1:0]     stack_mem [CELLS];

   // config registers
   logic [CSR_DATA_W-1:0] grid_width_ff, grid_width_in;
   logic [CSR_DATA_W-1:0] grid_height_ff, grid_height_in;
   logic                  fence_mode_ff, fence_mode_in;

   // control
   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] lc_ff, lc_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // compute context
   logic          mode_ff, mode_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CB-1:0] wm1_ff, wm1_in;
   logic [RB-1:0] hm1_ff, hm1_in;
   logic [AW-1:0] delta_ff [8];
   logic [AW-1:0] delta_in [8];
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [RB-1:0] sr_ff, sr_in;
   logic [CB-1:0] sc_ff, sc_in;
   logic [CW-1:0] sp_ff, sp_in;
   logic [AW-1:0] p_ff, p_in;
   logic [RB-1:0] r_ff, r_in;
   logic [CB-1:0] c_ff, c_in;
   logic [LABEL_W-1:0] lab_c_ff, lab_c_in;
   logic [7:0]    inb_ff, inb_in;
   logic [7:0]    sbits_ff, sbits_in;
   logic [2:0]    k_ff, k_in;
   logic [AW-1:0] nb_addr_ff, nb_addr_in;
   logic [CW-1:0] area_ff, area_in;
   logic [FB-1:0] perim_ff, perim_in;
   logic [FB-1:0] corner_ff, corner_in;
   logic [PRICE_W-1:0] price_ff, price_in;

   // memory ports
   logic               lab_we;
   logic [AW-1:0]      lab_ra;
   logic [LABEL_W-1:0] lab_rd_ff;
   logic               vis_we, vis_wd;
   logic [AW-1:0]      vis_wa, vis_ra;
   logic               vis_rd_ff;
   logic               stk_we;
   logic [AW-1:0]      stk_wa, stk_ra;
   logic [SEW-1:0]     stk_wd, stk_rd_ff;

   // clamped dimensions and grid size
   logic [WCB-1:0] w_clamp;
   logic [HCB-1:0] h_clamp;
   logic [GW-1:0]  grid_cells;
   logic [CW-1:0]  lc_next;
   logic [AW-1:0]  w_addr;
   logic           req_take;

   // neighbor helpers
   logic [AW-1:0]  nb_addr;
   logic           same;
   logic [RB-1:0]  nr;
   logic [CB-1:0]  nc;
   logic [2:0]     cell_corners;
   logic [AW-1:0]  stk_p;
   logic [RB-1:0]  stk_r;
   logic [CB-1:0]  stk_c;

   // region price unit
   grafs_mac_ctl_type  mac_ctl;
   logic               mac_busy;
   logic [PRICE_W-1:0] mac_sum;
   logic [FB-1:0]      mac_fence;

   grafs_mac #(
      .AREA_W  (CW),
      .FENCE_W (FB)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .area  (area_ff),
      .fence (mac_fence),
      .busy  (mac_busy),
      .sum   (mac_sum)
   );

   assign mac_fence = mode_ff ? corner_ff : perim_ff;

   always_comb begin
      if (grid_width_ff == '0) begin
         w_clamp = WCB'(1);
      end else if (DW'(grid_width_ff) > DW'(MAX_COLS)) begin
         w_clamp = WCB'(MAX_COLS);
      end else begin
         w_clamp = WCB'(grid_width_ff);
      end
      if (grid_height_ff == '0) begin
         h_clamp = HCB'(1);
      end else if (DW'(grid_height_ff) > DW'(MAX_ROWS)) begin
         h_clamp = HCB'(MAX_ROWS);
      end else begin
         h_clamp = HCB'(grid_height_ff);
      end
   end

   assign grid_cells = GW'(w_clamp) * GW'(h_clamp);
   assign lc_next    = lc_ff + CW'(1);
   assign w_addr     = AW'(w_clamp);
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;

   assign {stk_p, stk_r, stk_c} = stk_rd_ff;
   assign nb_addr = p_ff + delta_ff[k_ff];
   assign same    = inb_ff[k_ff] && (lab_rd_ff == lab_c_ff);

   // row and column of an orthogonal neighbor pushed on the stack
   always_comb begin
      nr = r_ff;
      nc = c_ff;
      case (k_ff)
         DIR_N:   nr = r_ff - RB'(1);
         DIR_S:   nr = r_ff + RB'(1);
         DIR_E:   nc = c_ff + CB'(1);
         DIR_W:   nc = c_ff - CB'(1);
         default: begin
            nr = r_ff;
            nc = c_ff;
         end
      endcase
   end

   // convex corners (both sides open) and concave corners (diagonal open)
   function automatic logic corner_at(input logic a, input logic b, input logic d);
      return (!a && !b) || (a && b && !d);
   endfunction

   assign cell_corners =
      3'(corner_at(sbits_ff[DIR_N], sbits_ff[DIR_W], sbits_ff[DIR_NW])) +
      3'(corner_at(sbits_ff[DIR_S], sbits_ff[DIR_W], sbits_ff[DIR_SW])) +
      3'(corner_at(sbits_ff[DIR_N], sbits_ff[DIR_E], sbits_ff[DIR_NE])) +
      3'(corner_at(sbits_ff[DIR_S], sbits_ff[DIR_E], sbits_ff[DIR_SE]));

   // sequencer
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      fence_mode_in  = fence_mode_ff;
      state_in       = state_ff;
      lc_in          = lc_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      price_in       = price_ff;
      mode_in        = mode_ff;
      total_in       = total_ff;
      wm1_in         = wm1_ff;
      hm1_in         = hm1_ff;
      delta_in       = delta_ff;
      cnt_in         = cnt_ff;
      sr_in          = sr_ff;
      sc_in          = sc_ff;
      sp_in          = sp_ff;
      p_in           = p_ff;
      r_in           = r_ff;
      c_in           = c_ff;
      lab_c_in       = lab_c_ff;
      inb_in         = inb_ff;
      sbits_in       = sbits_ff;
      k_in           = k_ff;
      nb_addr_in     = nb_addr_ff;
      area_in        = area_ff;
      perim_in       = perim_ff;
      corner_in      = corner_ff;

      lab_we  = 1'b0;
      lab_ra  = nb_addr;
      vis_we  = 1'b0;
      vis_wa  = cnt_ff[AW-1:0];
      vis_wd  = 1'b0;
      vis_ra  = nb_addr;
      stk_we  = 1'b0;
      stk_wa  = sp_ff[AW-1:0];
      stk_wd  = {cnt_ff[AW-1:0], sr_ff, sc_ff};
      stk_ra  = AW'(sp_ff - CW'(1));
      mac_ctl = '{clear: 1'b0, start: 1'b0};

      if (csr_write_enable) begin
         case (csr_index)
            REG_GRID_WIDTH:  grid_width_in  = csr_write_data;
            REG_GRID_HEIGHT: grid_height_in = csr_write_data;
            REG_FENCE_MODE:  fence_mode_in  = csr_write_data[0];
            default:         ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               lab_we = 1'b1;
               if (CMPW'(lc_next) >= CMPW'(grid_cells)) begin
                  // last cell: sample sizes and mode, start the computation
                  lc_in       = '0;
                  mode_in     = fence_mode_ff;
                  total_in    = CW'(grid_cells);
                  wm1_in      = CB'(w_clamp - WCB'(1));
                  hm1_in      = RB'(h_clamp - HCB'(1));
                  delta_in[DIR_N]  = AW'(0) - w_addr;
                  delta_in[DIR_S]  = w_addr;
                  delta_in[DIR_E]  = AW'(1);
                  delta_in[DIR_W]  = AW'(0) - AW'(1);
                  delta_in[DIR_NW] = AW'(0) - w_addr - AW'(1);
                  delta_in[DIR_NE] = AW'(0) - w_addr + AW'(1);
                  delta_in[DIR_SW] = w_addr - AW'(1);
                  delta_in[DIR_SE] = w_addr + AW'(1);
                  cnt_in      = '0;
                  mac_ctl.clear = 1'b1;
                  state_in    = ST_CLEAR;
               end else begin
                  lc_in = lc_next;
               end
            end
         end
         ST_CLEAR: begin
            vis_we = 1'b1;
            vis_wd = 1'b0;
            if (cnt_ff == total_ff - CW'(1)) begin
               cnt_in   = '0;
               sr_in    = '0;
               sc_in    = '0;
               state_in = ST_SCAN_RD;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_SCAN_RD: begin
            vis_ra = cnt_ff[AW-1:0];
            if (cnt_ff == total_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (!vis_rd_ff) begin
               // seed a new region at the bottom of the stack
               vis_we    = 1'b1;
               vis_wd    = 1'b1;
               stk_we    = 1'b1;
               stk_wa    = '0;
               sp_in     = CW'(1);
               area_in   = '0;
               perim_in  = '0;
               corner_in = '0;
               state_in  = ST_POP;
            end else begin
               state_in = ST_SCAN_RD;
            end
            cnt_in = cnt_ff + CW'(1);
            if (sc_ff == wm1_ff) begin
               sc_in = '0;
               sr_in = sr_ff + RB'(1);
            end else begin
               sc_in = sc_ff + CB'(1);
            end
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               mac_ctl.start = 1'b1;
               state_in      = ST_MAC;
            end else begin
               sp_in    = sp_ff - CW'(1);
               state_in = ST_POP_W;
            end
         end
         ST_POP_W: begin
            p_in     = stk_p;
            r_in     = stk_r;
            c_in     = stk_c;
            lab_ra   = stk_p;
            state_in = ST_CTR;
         end
         ST_CTR: begin
            lab_c_in = lab_rd_ff;
            inb_in[DIR_N]  = (r_ff != '0);
            inb_in[DIR_S]  = (r_ff != hm1_ff);
            inb_in[DIR_E]  = (c_ff != wm1_ff);
            inb_in[DIR_W]  = (c_ff != '0);
            inb_in[DIR_NW] = (r_ff != '0) && (c_ff != '0);
            inb_in[DIR_NE] = (r_ff != '0) && (c_ff != wm1_ff);
            inb_in[DIR_SW] = (r_ff != hm1_ff) && (c_ff != '0);
            inb_in[DIR_SE] = (r_ff != hm1_ff) && (c_ff != wm1_ff);
            k_in     = DIR_N;
            state_in = ST_NRD;
         end
         ST_NRD: begin
            nb_addr_in = nb_addr;
            state_in   = ST_NEV;
         end
         ST_NEV: begin
            sbits_in[k_ff] = same;
            if (!k_ff[2]) begin
               if (!same) begin
                  perim_in = perim_ff + FB'(1);
               end else if (!vis_rd_ff) begin
                  vis_we = 1'b1;
                  vis_wa = nb_addr_ff;
                  vis_wd = 1'b1;
                  stk_we = 1'b1;
                  stk_wd = {nb_addr_ff, nr, nc};
                  sp_in  = sp_ff + CW'(1);
               end
            end
            if (k_ff == DIR_SE) begin
               state_in = ST_CEND;
            end else begin
               k_in     = k_ff + 3'd1;
               state_in = ST_NRD;
            end
         end
         ST_CEND: begin
            area_in   = area_ff + CW'(1);
            corner_in = corner_ff + FB'(cell_corners);
            state_in  = ST_POP;
         end
         ST_MAC: begin
            if (!mac_busy) begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               price_in     = mac_sum;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         lc_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
         grid_width_ff  <= CSR_DATA_W'(128);
         grid_height_ff <= CSR_DATA_W'(128);
         fence_mode_ff  <= 1'b1;
      end else begin
         state_ff       <= state_in;
         lc_ff          <= lc_in;
         rsp_valid_ff   <= rsp_valid_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         fence_mode_ff  <= fence_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff   <= price_in;
      mode_ff    <= mode_in;
      total_ff   <= total_in;
      wm1_ff     <= wm1_in;
      hm1_ff     <= hm1_in;
      delta_ff   <= delta_in;
      cnt_ff     <= cnt_in;
      sr_ff      <= sr_in;
      sc_ff      <= sc_in;
      sp_ff      <= sp_in;
      p_ff       <= p_in;
      r_ff       <= r_in;
      c_ff       <= c_in;
      lab_c_ff   <= lab_c_in;
      inb_ff     <= inb_in;
      sbits_ff   <= sbits_in;
      k_ff       <= k_in;
      nb_addr_ff <= nb_addr_in;
      area_ff    <= area_in;
      perim_ff   <= perim_in;
      corner_ff  <= corner_in;
   end

   // label store
   always_ff @(posedge clock) begin
      if (lab_we) begin
         label_mem[lc_ff[AW-1:0]] <= req_cell_label;
      end
      lab_rd_ff <= label_mem[lab_ra];
   end

   // visited map
   always_ff @(posedge clock) begin
      if (vis_we) begin
         visit_mem[vis_wa] <= vis_wd;
      end
      vis_rd_ff <= visit_mem[vis_ra];
   end

   // fill stack
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_wa] <= stk_wd;
      end
      stk_rd_ff <= stack_mem[stk_ra];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_total_price = price_ff;

   // a result only appears when the computation has finished
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

   // an empty stack at a region end launches the price unit
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP && sp_ff == '0) |=> mac_busy)
      else $error("price unit not started at region end");

   // a cell transaction leaves the block loading or clearing
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_IDLE || state_ff == ST_CLEAR))
      else $error("unexpected state after a cell transaction");

endmodule
